// ----- rtl/unique_key_priority_queue_macros.svh -----
// Assertion macros used by the property checker in rtl/uqpq_checker.sv.
`ifndef UNIQUE_KEY_PRIORITY_QUEUE_MACROS_SVH
`define UNIQUE_KEY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define UQPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define UQPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/uqpq_pkg.sv -----
`default_nettype none

package uqpq_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 16;
    localparam int TAG_W = 16;
    localparam int POS_W = 5;
    localparam int OCC_W = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [KEY_W-1:0]   key;
        logic        [TAG_W-1:0]   tag;
        logic        [POS_W-1:0]   position;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [KEY_W-1:0]   out_key;
        logic        [TAG_W-1:0]   out_tag;
        logic        [OCC_W-1:0]   occupancy;
    } rsp_t;

    typedef struct packed {
        logic                      valid;
        logic signed [KEY_W-1:0]   key;
        logic        [TAG_W-1:0]   tag;
    } entry_t;

    // per-cell control: operation plus "take neighbour above" for removal
    typedef struct packed {
        cell_op_t                  op;
        logic                      from_next;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/unique_key_priority_queue.sv -----
// The response word is registered and valid in the cycle after the command is accepted.
// Throughput: one command word per cycle unless a held response stalls it;
// every cell of the sorted row compares and shifts in parallel, so the row updates at once.
// Reset: entry count, cell valid bits and response valid clear at once;
// stored keys and tags are left as they are and never read while invalid.
`default_nettype none

module unique_key_priority_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire uqpq_pkg::cmd_t    cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output uqpq_pkg::rsp_t         rsp
);

    // Control and response registers
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    uqpq_pkg::rsp_t                rsp_reg;
    uqpq_pkg::rsp_t                rsp_next;
    logic [uqpq_pkg::CNT_W-1:0]    cnt_reg;
    logic [uqpq_pkg::CNT_W-1:0]    cnt_next;

    logic                          accept;
    logic                          dup;
    logic                          full;
    logic                          empty;
    logic [uqpq_pkg::POS_W-1:0]    idx;
    logic                          idx_ok;
    uqpq_pkg::cell_op_t            op;
    uqpq_pkg::entry_t              ins;
    uqpq_pkg::entry_t              picked;

    // Row of cells: cell 0 holds the smallest key
    uqpq_pkg::entry_t              cells     [uqpq_pkg::DEPTH];
    logic [uqpq_pkg::DEPTH-1:0]    lt;
    logic [uqpq_pkg::DEPTH-1:0]    eq;
    logic [uqpq_pkg::DEPTH-1:0]    sel;
    uqpq_pkg::cell_ctl_t           ctl       [uqpq_pkg::DEPTH];

    // The response register frees itself as soon as the word is taken, so
    // a new command only waits while a finished word is being held back.
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ins.valid = 1'b1;
    assign ins.key   = cmd.key;
    assign ins.tag   = cmd.tag;

    assign dup   = |eq;
    assign full  = (cnt_reg == uqpq_pkg::CNT_W'(uqpq_pkg::DEPTH));
    assign empty = (cnt_reg == '0);

    // Positions 0 and 1 both name the head; pop always works on the head.
    always_comb
    begin
        if (cmd.opcode == uqpq_pkg::OP_DELETE && cmd.position > uqpq_pkg::POS_W'(1))
        begin
            idx = cmd.position - uqpq_pkg::POS_W'(1);
        end
        else
        begin
            idx = '0;
        end
    end

    assign idx_ok = (uqpq_pkg::CMP_W'(idx) < uqpq_pkg::CMP_W'(cnt_reg));

    for (genvar i = 0; i < uqpq_pkg::DEPTH; i++)
    begin : g_cell
        uqpq_pkg::entry_t prev_e;
        uqpq_pkg::entry_t next_e;
        logic             prev_lt;

        assign sel[i]          = (uqpq_pkg::CMP_W'(i) == uqpq_pkg::CMP_W'(idx));
        assign ctl[i].op       = op;
        assign ctl[i].from_next = (uqpq_pkg::CMP_W'(i) >= uqpq_pkg::CMP_W'(idx));

        if (i == 0)
        begin : g_head
            // nothing below the head: an insert that reaches it lands here
            assign prev_e  = '0;
            assign prev_lt = 1'b1;
        end
        else
        begin : g_body
            assign prev_e  = cells[i-1];
            assign prev_lt = lt[i-1];
        end

        if (i == uqpq_pkg::DEPTH - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_mid
            assign next_e = cells[i+1];
        end

        uqpq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[i]),
            .ins     (ins),
            .prev    (prev_e),
            .prev_lt (prev_lt),
            .next    (next_e),
            .cur     (cells[i]),
            .lt      (lt[i]),
            .eq      (eq[i])
        );
    end

    // Word leaving the row on pop or delete
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < uqpq_pkg::DEPTH; i++)
        begin
            if (sel[i])
            begin
                picked = picked | cells[i];
            end
        end
    end

    // Decode: duplicate is checked ahead of full
    always_comb
    begin
        op                 = uqpq_pkg::CELL_HOLD;
        cnt_next           = cnt_reg;
        rsp_next.status    = uqpq_pkg::ST_OK;
        rsp_next.out_key   = '0;
        rsp_next.out_tag   = '0;
        unique case (cmd.opcode)
            uqpq_pkg::OP_INSERT:
            begin
                if (dup)
                begin
                    rsp_next.status = uqpq_pkg::ST_DUP;
                end
                else if (full)
                begin
                    rsp_next.status = uqpq_pkg::ST_FULL;
                end
                else
                begin
                    op       = uqpq_pkg::CELL_INSERT;
                    cnt_next = cnt_reg + uqpq_pkg::CNT_W'(1);
                end
            end
            uqpq_pkg::OP_POP, uqpq_pkg::OP_DELETE:
            begin
                if (empty)
                begin
                    rsp_next.status = uqpq_pkg::ST_EMPTY;
                end
                else if (!idx_ok)
                begin
                    rsp_next.status = uqpq_pkg::ST_BADPOS;
                end
                else
                begin
                    op               = uqpq_pkg::CELL_REMOVE;
                    cnt_next         = cnt_reg - uqpq_pkg::CNT_W'(1);
                    rsp_next.out_key = picked.key;
                    rsp_next.out_tag = picked.tag;
                end
            end
            default:
            begin
            end
        endcase
        if (!accept)
        begin
            op       = uqpq_pkg::CELL_HOLD;
            cnt_next = cnt_reg;
        end
        rsp_next.occupancy = uqpq_pkg::OCC_W'(cnt_next);
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/uqpq_cell.sv -----
`default_nettype none

module uqpq_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire uqpq_pkg::cell_ctl_t           ctl,
    input  wire uqpq_pkg::entry_t              ins,
    input  wire uqpq_pkg::entry_t              prev,
    input  wire logic                          prev_lt,
    input  wire uqpq_pkg::entry_t              next,
    output uqpq_pkg::entry_t                   cur,
    output logic                               lt,
    output logic                               eq
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [uqpq_pkg::KEY_W-1:0]   key_reg;
    logic signed [uqpq_pkg::KEY_W-1:0]   key_next;
    logic        [uqpq_pkg::TAG_W-1:0]   tag_reg;
    logic        [uqpq_pkg::TAG_W-1:0]   tag_next;

    assign lt = valid_reg && ($signed(key_reg) < $signed(ins.key));
    assign eq = valid_reg && (key_reg == ins.key);

    assign cur.valid = valid_reg;
    assign cur.key   = key_reg;
    assign cur.tag   = tag_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        unique case (ctl.op)
            uqpq_pkg::CELL_INSERT:
            begin
                // smaller keys stay put; the first larger slot takes the new word
                if (!lt)
                begin
                    if (prev_lt)
                    begin
                        valid_next = 1'b1;
                        key_next   = ins.key;
                        tag_next   = ins.tag;
                    end
                    else
                    begin
                        valid_next = prev.valid;
                        key_next   = prev.key;
                        tag_next   = prev.tag;
                    end
                end
            end
            uqpq_pkg::CELL_REMOVE:
            begin
                if (ctl.from_next)
                begin
                    valid_next = next.valid;
                    key_next   = next.key;
                    tag_next   = next.tag;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

// ----- rtl/uqpq_checker.sv -----
`default_nettype none
`include "unique_key_priority_queue_macros.svh"

module uqpq_props (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic              cmd_stall,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire uqpq_pkg::rsp_t    rsp
);

    `UQPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response word dropped or changed while stalled")
    `UQPQ_ASSERT_NEXT(a_one_cycle, cmd_valid && !cmd_stall, rsp_valid, "no response one cycle after accept")
    `UQPQ_ASSERT_NOW(a_stall_cause, cmd_stall, rsp_valid && rsp_stall, "command stalled with the response slot free")
    `UQPQ_ASSERT_NOW(a_occ_range, rsp_valid, rsp.occupancy <= uqpq_pkg::DEPTH, "occupancy beyond queue depth")
    `UQPQ_ASSERT_NOW(a_zero_fail, rsp_valid && rsp.status != uqpq_pkg::ST_OK, rsp.out_key == '0 && rsp.out_tag == '0, "failed operation returned an entry")

endmodule

bind unique_key_priority_queue uqpq_props u_uqpq_props (.*);

`default_nettype wire

// ----- test/uqpq_checker.sv -----
`timescale 1ns / 100ps

module uqpq_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic             cmd_stall,
    input  wire uqpq_pkg::cmd_t   cmd,
    input  wire logic             rsp_valid,
    input  wire logic             rsp_stall,
    input  wire uqpq_pkg::rsp_t   rsp,
    output int                    errors,
    output int                    owed
);
    import uqpq_pkg::*;

    // shadow of the sorted row, ascending signed key
    logic signed [KEY_W-1:0] row_key [DEPTH];
    logic        [TAG_W-1:0] row_tag [DEPTH];
    int                      row_count;
    rsp_t                    rsp_owed [$];
    int                      shown;

    // pull one entry out of the row and close the hole
    task automatic take_entry(input int idx, inout rsp_t r);
        r.out_key = row_key[idx];
        r.out_tag = row_tag[idx];
        for (int i = idx; i + 1 < row_count; i++)
        begin
            row_key[i] = row_key[i + 1];
            row_tag[i] = row_tag[i + 1];
        end
        row_count--;
    endtask

    task automatic serve_command(input cmd_t c, output rsp_t r);
        int  slot;
        int  idx;
        bit  dup;
        r = '0;
        r.status = ST_OK;
        case (c.opcode)
            OP_INSERT:
            begin
                dup  = 1'b0;
                slot = 0;
                for (int i = 0; i < row_count; i++)
                begin
                    if (row_key[i] == $signed(c.key))
                        dup = 1'b1;
                    if (row_key[i] < $signed(c.key))
                        slot++;
                end
                // duplicate wins over full
                if (dup)
                    r.status = ST_DUP;
                else if (row_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = row_count; i > slot; i--)
                    begin
                        row_key[i] = row_key[i - 1];
                        row_tag[i] = row_tag[i - 1];
                    end
                    row_key[slot] = c.key;
                    row_tag[slot] = c.tag;
                    row_count++;
                end
            end
            OP_POP:
            begin
                if (row_count == 0)
                    r.status = ST_EMPTY;
                else
                    take_entry(0, r);
            end
            OP_DELETE:
            begin
                if (row_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    idx = (c.position <= 1) ? 0 : int'(c.position) - 1;
                    if (idx >= row_count)
                        r.status = ST_BADPOS;
                    else
                        take_entry(idx, r);
                end
            end
            default: ;
        endcase
        r.occupancy = row_count[OCC_W-1:0];
    endtask

    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            row_count = 0;
            rsp_owed.delete();
            errors = 0;
            shown  = 0;
        end
        else
        begin
            // results first: a word's own result never comes on its accept edge
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_owed.size() == 0)
                begin
                    errors++;
                    if (shown < 10)
                        $display("%t: unexpected result word %p", $realtime, rsp);
                    shown++;
                end
                else
                begin
                    want = rsp_owed.pop_front();
                    if (rsp.status !== want.status || rsp.out_key !== want.out_key ||
                        rsp.out_tag !== want.out_tag || rsp.occupancy !== want.occupancy)
                    begin
                        errors++;
                        if (shown < 10)
                            $display("%t: mismatch exp st %0d key %0d tag %0h occ %0d, got st %0d key %0d tag %0h occ %0d",
                                     $realtime, want.status, want.out_key, want.out_tag,
                                     want.occupancy, rsp.status, rsp.out_key, rsp.out_tag,
                                     rsp.occupancy);
                        shown++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                serve_command(cmd, want);
                rsp_owed.push_back(want);
            end
        end
        owed = rsp_owed.size();
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import uqpq_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int errors;
    int owed;

    // while set, neither side idles: back-to-back words at full rate
    bit calm = 1'b0;

    always #2 clk = ~clk;

    unique_key_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    uqpq_checker rsp_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .owed      (owed)
    );

    // Idle length: mostly none, otherwise a short gap or now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cmd_t make_cmd(opcode_t op, logic [KEY_W-1:0] key,
                                      logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
        cmd_t c;
        c.opcode   = op;
        c.key      = key;
        c.tag      = tag;
        c.position = pos;
        return c;
    endfunction

    // Keys: full-range random, a narrow pool so duplicates are common, or an extreme.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return KEY_W'($urandom_range(0, 65535));
        if (roll < 85)
            return KEY_W'($urandom_range(0, 24) - 12);
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'h7fff;
            3:       return 16'h7ffe;
            4:       return 16'hffff;
            default: return 16'h0000;
        endcase
    endfunction

    // Present one word and hold it until the block takes it.
    // valid is only lowered when a gap is due, so back-to-back words keep it high.
    task automatic send_word(input cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Result side back-pressure, independent of anything on the command side.
    initial
    begin : stall_gen
        int hold;
        forever
        begin
            @(posedge clk);
            hold = pick_gap();
            rsp_stall <= (hold != 0);
            if (hold > 1)
                repeat (hold - 1) @(posedge clk);
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int ins_pct;
        int roll;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: empty-queue cases, unused opcode, key extremes ---
        send_word(make_cmd(OP_POP,    16'h0000, 16'h0000, 5'd0));
        send_word(make_cmd(OP_DELETE, 16'h0000, 16'h0000, 5'd0));
        send_word(make_cmd(OP_NONE,   16'hffff, 16'hffff, 5'd31));
        send_word(make_cmd(OP_INSERT, 16'h7fff, 16'hffff, 5'd0));
        send_word(make_cmd(OP_INSERT, 16'h8000, 16'h0000, 5'd0));
        send_word(make_cmd(OP_INSERT, 16'h0000, 16'h1234, 5'd0));
        // same key again: rejected as duplicate
        send_word(make_cmd(OP_INSERT, 16'h0000, 16'h5678, 5'd0));
        // positions past the end
        send_word(make_cmd(OP_DELETE, 16'h0000, 16'h0000, 5'd31));
        send_word(make_cmd(OP_DELETE, 16'h0000, 16'h0000, 5'd4));
        // middle, head by pop, head by position 1
        send_word(make_cmd(OP_DELETE, 16'h0000, 16'h0000, 5'd2));
        send_word(make_cmd(OP_POP,    16'h0000, 16'h0000, 5'd0));
        send_word(make_cmd(OP_DELETE, 16'h0000, 16'h0000, 5'd1));

        // fill in descending key order so every insert lands at the head
        for (int i = 0; i < DEPTH; i++)
            send_word(make_cmd(OP_INSERT, KEY_W'(100 - 7 * i), TAG_W'(i), 5'd0));
        // new key into a full queue, then a duplicate while full
        send_word(make_cmd(OP_INSERT, 16'd5000, 16'habcd, 5'd0));
        send_word(make_cmd(OP_INSERT, 16'd100,  16'h4321, 5'd0));

        // --- random: phases biased to fill, churn or drain the queue ---
        for (int ph = 0; ph < 25; ph++)
        begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 85;
                1:       ins_pct = 50;
                default: ins_pct = 20;
            endcase
            calm = ($urandom_range(0, 5) == 0);
            for (int n = 0; n < 50; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                    send_word(make_cmd(OP_INSERT, pick_key(),
                                       TAG_W'($urandom_range(0, 65535)), 5'd0));
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 40)
                        send_word(make_cmd(OP_POP, pick_key(),
                                           TAG_W'($urandom_range(0, 65535)),
                                           POS_W'($urandom_range(0, 31))));
                    else if (roll < 95)
                        send_word(make_cmd(OP_DELETE, pick_key(),
                                           TAG_W'($urandom_range(0, 65535)),
                                           ($urandom_range(0, 4) == 0) ?
                                           POS_W'($urandom_range(0, 31)) :
                                           POS_W'($urandom_range(0, 17))));
                    else
                        send_word(make_cmd(OP_NONE, pick_key(),
                                           TAG_W'($urandom_range(0, 65535)),
                                           POS_W'($urandom_range(0, 31))));
                end
            end
        end
        calm = 1'b0;

        // --- drain and verdict ---
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        // spare edges after the drain catch any stray result word
        repeat (8) @(posedge clk);
        if (errors == 0 && owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- unique_key_priority_queue.f -----
+incdir+rtl
rtl/uqpq_pkg.sv
rtl/uqpq_cell.sv
rtl/unique_key_priority_queue.sv
rtl/uqpq_checker.sv
test/uqpq_checker.sv
test/tb_top.sv
